[src/iss_pkg.sv]
// package: shared types and constants of the integer set store
`timescale 1ns / 1ps
package iss_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_MEMBER  = 2'd2,
    OP_EXTRACT = 2'd3
  } opcode_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_BUSY = 1'b1
  } state_e;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic                      cmp_en;
    logic                      upd_en;
    opcode_e                   op;
    logic signed [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage

[src/iss_if.sv]
// interfaces: request and response channels of the integer set store
`timescale 1ns / 1ps
interface iss_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface iss_rsp_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic signed [31:0] extracted;
  logic [4:0]         count;

  modport source (output valid, output ok, output extracted, output count, input ready);
  modport sink   (input valid, input ok, input extracted, input count, output ready);
endinterface

[src/iss_cell.sv]
// module: one storage cell of the set chain, with compare, shift and tail tap
`timescale 1ns / 1ps
module iss_cell #(
  parameter int unsigned Idx    = 0,
  parameter int unsigned CountW = 5
) (
  input  logic                              clk_i,
  input  iss_pkg::cell_ctrl_t               ctrl_i,
  input  logic [CountW-1:0]                 count_i,
  input  logic signed [iss_pkg::VALUE_W-1:0] next_value_i,
  input  logic                              hit_i,
  input  logic signed [iss_pkg::VALUE_W-1:0] take_i,
  output logic signed [iss_pkg::VALUE_W-1:0] value_o,
  output logic                              hit_o,
  output logic signed [iss_pkg::VALUE_W-1:0] take_o
);
  import iss_pkg::*;

  logic signed [VALUE_W-1:0] entry_q;
  logic                      match_q;
  logic                      occupied;
  logic                      is_tail;
  logic                      is_free;

  assign occupied = CountW'(Idx) < count_i;
  assign is_tail  = count_i == CountW'(Idx + 1);
  assign is_free  = count_i == CountW'(Idx);

  // hit ripples upward: set in this cell and all above the matching one
  assign hit_o   = hit_i | match_q;
  assign take_o  = take_i | (is_tail ? entry_q : '0);
  assign value_o = entry_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp_en) begin
      match_q <= occupied && (entry_q == ctrl_i.value);
    end
    if (ctrl_i.upd_en) begin
      case (ctrl_i.op)
        OP_REMOVE: begin
          if (hit_o) begin
            entry_q <= next_value_i;
          end
        end
        OP_ADD: begin
          // writing past the tail is harmless when the add is refused
          if (is_free) begin
            entry_q <= ctrl_i.value;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[src/integer_set_store.sv]
// top level: integer set store built as a chain of storage cells
//
//   channel  | dir | payload                   | transaction when
//   ---------+-----+---------------------------+---------------------
//   req_i    | in  | opcode, value             | valid && ready
//   rsp_o    | out | ok, extracted, count      | valid && ready
//
// for each request the accept edge registers a compare in every cell; in the busy
// state the commit edge ripples the hit through the chain, shifts or writes the
// cells and loads the response register
// the ripple through all EntryCount cells sets the cycle time
// after reset the store is empty and a request is taken at once
// a stalled response holds the store in its busy state until the response
// register is free; requests wait meanwhile
`timescale 1ns / 1ps
module integer_set_store #(
  parameter int unsigned EntryCount = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  iss_req_if.sink   req_i,
  iss_rsp_if.source rsp_o
);
  import iss_pkg::*;

  localparam int unsigned CountW = $clog2(EntryCount + 1);

  state_e state_q, state_d;

  // latched request
  opcode_e                   op_q;
  logic signed [VALUE_W-1:0] value_q;

  // number of held entries
  logic [CountW-1:0] cnt_q, cnt_d;

  // response register
  logic                      rsp_valid_q;
  logic                      ok_q, ok_d;
  logic signed [VALUE_W-1:0] extracted_q, extracted_d;
  logic [COUNT_W-1:0]        count_q;

  logic req_fire;
  logic commit;

  cell_ctrl_t ctrl;

  // chain wiring
  logic                      hit_c  [EntryCount+1];
  logic signed [VALUE_W-1:0] take_c [EntryCount+1];
  logic signed [VALUE_W-1:0] cell_value [EntryCount];

  assign req_fire = req_i.valid && req_i.ready;
  assign commit   = (state_q == ST_BUSY) && (!rsp_valid_q || rsp_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (req_fire) state_d = ST_BUSY;
      ST_BUSY: if (commit)   state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req_i.ready  = 1'b0;
    ctrl.cmp_en  = 1'b0;
    ctrl.upd_en  = 1'b0;
    ctrl.op      = op_q;
    ctrl.value   = value_q;
    unique case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        ctrl.cmp_en = req_fire;
        // compare runs against the incoming value at the accept edge
        ctrl.value  = req_i.value;
      end
      ST_BUSY: begin
        ctrl.upd_en = commit;
      end
      default: begin
      end
    endcase
  end

  // the cell chain
  assign hit_c[0]  = 1'b0;
  assign take_c[0] = '0;

  for (genvar i = 0; i < EntryCount; i++) begin : g_cell
    logic signed [VALUE_W-1:0] next_value;
    if (i == EntryCount - 1) begin : g_last
      assign next_value = cell_value[i];
    end else begin : g_mid
      assign next_value = cell_value[i+1];
    end

    iss_cell #(
      .Idx    (i),
      .CountW (CountW)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .count_i      (cnt_q),
      .next_value_i (next_value),
      .hit_i        (hit_c[i]),
      .take_i       (take_c[i]),
      .value_o      (cell_value[i]),
      .hit_o        (hit_c[i+1]),
      .take_o       (take_c[i+1])
    );
  end

  // outcome of the request from the chain ends
  always_comb begin
    ok_d        = 1'b0;
    extracted_d = '0;
    cnt_d       = cnt_q;
    case (op_q)
      OP_ADD: begin
        if (!hit_c[EntryCount] && (cnt_q < CountW'(EntryCount))) begin
          ok_d  = 1'b1;
          cnt_d = cnt_q + CountW'(1);
        end
      end
      OP_REMOVE: begin
        if (hit_c[EntryCount]) begin
          ok_d  = 1'b1;
          cnt_d = cnt_q - CountW'(1);
        end
      end
      OP_MEMBER: begin
        ok_d = hit_c[EntryCount];
      end
      default: begin
        // extract last entry
        if (cnt_q != '0) begin
          ok_d        = 1'b1;
          extracted_d = take_c[EntryCount];
          cnt_d       = cnt_q - CountW'(1);
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        cnt_q       <= cnt_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q    <= opcode_e'(req_i.opcode);
      value_q <= req_i.value;
    end
    if (commit) begin
      ok_q        <= ok_d;
      extracted_q <= extracted_d;
      count_q     <= COUNT_W'(cnt_d);
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.ok        = ok_q;
  assign rsp_o.extracted = extracted_q;
  assign rsp_o.count     = count_q;

endmodule

[test/tb_integer_set_store.sv]
// testbench: directed and random transactions against a predictor of the integer set store
`timescale 1ns / 1ps
module tb_integer_set_store;
  import iss_pkg::*;

  localparam int unsigned ENTRY_COUNT = 16;
  localparam int unsigned POOL_SIZE   = 24;
  // cycles in a row without any transaction before the run is called hung
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 120;

  typedef struct {
    logic                      ok;
    logic signed [VALUE_W-1:0] extracted;
    logic [COUNT_W-1:0]        count;
  } set_reply_t;

  logic clk;
  logic rst_n;

  iss_req_if req_if ();
  iss_rsp_if rsp_if ();

  integer_set_store #(
    .EntryCount(ENTRY_COUNT)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // predicted copy of the store
  logic signed [VALUE_W-1:0] model_vals [ENTRY_COUNT];
  int unsigned               model_len;

  set_reply_t                predicted_replies [$];
  logic signed [VALUE_W-1:0] value_pool [POOL_SIZE];

  int unsigned mismatch_count = 0;
  int unsigned stall_cycles   = 0;
  int unsigned sink_hold_left = 0;
  bit          source_idle_en = 1'b1;
  bit          sink_idle_en   = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // apply one request to the predicted store and return its reply
  function automatic set_reply_t apply_set_op(opcode_e op, logic signed [VALUE_W-1:0] v);
    set_reply_t  rep;
    int unsigned slot;
    slot          = model_len;
    rep.ok        = 1'b0;
    rep.extracted = '0;
    for (int unsigned i = 0; i < model_len; i++) begin
      if (model_vals[i] == v && slot == model_len) slot = i;
    end
    case (op)
      OP_ADD: begin
        if (slot == model_len && model_len < ENTRY_COUNT) begin
          model_vals[model_len] = v;
          model_len++;
          rep.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (slot < model_len) begin
          // later entries close the gap
          for (int unsigned i = slot; i + 1 < model_len; i++) model_vals[i] = model_vals[i + 1];
          model_len--;
          rep.ok = 1'b1;
        end
      end
      OP_MEMBER: begin
        rep.ok = (slot < model_len);
      end
      default: begin
        if (model_len > 0) begin
          model_len--;
          rep.extracted = model_vals[model_len];
          rep.ok        = 1'b1;
        end
      end
    endcase
    rep.count = model_len[COUNT_W-1:0];
    return rep;
  endfunction

  function automatic opcode_e pick_opcode(int unsigned add_w, int unsigned rem_w,
                                          int unsigned mem_w);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < add_w) return OP_ADD;
    if (r < add_w + rem_w) return OP_REMOVE;
    if (r < add_w + rem_w + mem_w) return OP_MEMBER;
    return OP_EXTRACT;
  endfunction

  // mostly pool values so that duplicates and hits are common
  function automatic logic signed [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 80) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // offer one request and record its prediction once it is taken
  task automatic send_request(opcode_e op, logic signed [VALUE_W-1:0] v);
    int unsigned gap;
    gap = 0;
    if (source_idle_en && $urandom_range(0, 99) < 18) gap = $urandom_range(1, 4);
    @(negedge clk);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid  <= 1'b1;
    req_if.opcode <= op;
    req_if.value  <= v;
    do begin
      @(posedge clk);
    end while (!req_if.ready);
    predicted_replies.push_back(apply_set_op(op, v));
  endtask

  // lower valid and wait for every outstanding reply
  task automatic drain_results();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (predicted_replies.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_store();
    send_request(OP_MEMBER, 32'sh8000_0000);
    send_request(OP_REMOVE, 32'sh7fff_ffff);
    send_request(OP_EXTRACT, 32'shffff_ffff);
  endtask

  task automatic test_add_and_duplicate();
    send_request(OP_ADD, 32'sh8000_0000);
    send_request(OP_ADD, 32'sh8000_0000);
    send_request(OP_ADD, 32'sh7fff_ffff);
    send_request(OP_ADD, 32'sh0000_0000);
    send_request(OP_ADD, 32'shffff_ffff);
  endtask

  task automatic test_member_and_remove();
    send_request(OP_MEMBER, 32'sh7fff_ffff);
    send_request(OP_MEMBER, 32'sh0000_0001);
    // middle entry, so the tail has to shift down
    send_request(OP_REMOVE, 32'sh0000_0000);
    send_request(OP_REMOVE, 32'sh0000_0000);
    send_request(OP_EXTRACT, 32'sh1234_5678);
  endtask

  task automatic test_full_store();
    int unsigned k;
    k = 0;
    while (model_len < ENTRY_COUNT) begin
      send_request(OP_ADD, 32'sh1000_0000 + k * 32'sh0101_0101);
      k++;
    end
    // full: a new value and a duplicate are both refused
    send_request(OP_ADD, 32'sh5a5a_5a5a);
    send_request(OP_ADD, 32'sh8000_0000);
  endtask

  // receiver holds off while the sender keeps offering, so input stalls
  task automatic test_sink_hold_off();
    sink_hold_left = HOLD_CYCLES;
    for (int unsigned i = 0; i < 10; i++) send_request(pick_opcode(40, 20, 20), pick_value());
    drain_results();
  endtask

  task automatic test_random_traffic(int unsigned n_items);
    int unsigned bias;
    bias = 0;
    for (int unsigned sent = 0; sent < n_items; sent++) begin
      // bias shifts every 40 items so the store swings between full and empty
      if (sent % 40 == 0) bias = $urandom_range(0, 2);
      case (bias)
        0:       send_request(pick_opcode(60, 15, 15), pick_value());
        1:       send_request(pick_opcode(15, 35, 15), pick_value());
        default: send_request(pick_opcode(30, 25, 25), pick_value());
      endcase
    end
    drain_results();
  endtask

  // receiver: random stalls, or a counted hold-off when asked
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        sink_hold_left--;
      end else if (sink_idle_en) begin
        rsp_if.ready <= ($urandom_range(0, 99) >= 18);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // compare every reply transaction with the oldest prediction
  always @(posedge clk) begin
    set_reply_t exp_rep;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (predicted_replies.size() == 0) begin
        $error("reply with no request outstanding");
        mismatch_count++;
      end else begin
        exp_rep = predicted_replies.pop_front();
        if (rsp_if.ok !== exp_rep.ok) begin
          $error("ok: expected %0d, actual %0d", exp_rep.ok, rsp_if.ok);
          mismatch_count++;
        end
        if (rsp_if.extracted !== exp_rep.extracted) begin
          $error("extracted: expected %0d, actual %0d", exp_rep.extracted, rsp_if.extracted);
          mismatch_count++;
        end
        if (rsp_if.count !== exp_rep.count) begin
          $error("count: expected %0d, actual %0d", exp_rep.count, rsp_if.count);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL integer_set_store");
        $finish;
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    req_if.valid  = 1'b0;
    req_if.opcode = OP_ADD;
    req_if.value  = '0;
    model_len     = 0;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = 32'sh0000_0000;
    value_pool[3] = 32'shffff_ffff;
    for (int unsigned i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_store();
    test_add_and_duplicate();
    test_member_and_remove();
    test_full_store();
    // sender pauses here until every reply is back
    drain_results();
    test_sink_hold_off();
    test_random_traffic(300);
    // long stretch with no idling on either side
    source_idle_en = 1'b0;
    sink_idle_en   = 1'b0;
    test_random_traffic(150);
    source_idle_en = 1'b1;
    sink_idle_en   = 1'b1;
    test_random_traffic(250);

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && predicted_replies.size() == 0) begin
      $display("PASS integer_set_store");
    end else begin
      $display("FAIL integer_set_store");
    end
    $finish;
  end

endmodule
